/* rtl/core/stt_pkg.sv */
// shared types and constants for the segment table translator
`default_nettype none

package stt_pkg;

    localparam int KIB_W    = 7;
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int LEFT_W   = 17;
    localparam int IDX_W    = 3;
    localparam int KIB_MAX  = 64;
    localparam int KIB_SHIFT = 10;
    localparam logic [KIB_W-1:0] KIB_RESET = 7'd16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOMEM = 2'd2,
        ST_SEGV  = 2'd3
    } t_status;

    typedef enum logic {
        FN_ADD       = 1'b0,
        FN_TRANSLATE = 1'b1
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [SIZE_W-1:0]   seg_size;
        logic [ADDR_W-1:0]   segment_number;
        logic [ADDR_W-1:0]   seg_offset;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    segment_index;
        logic [ADDR_W-1:0]   physical_address;
        logic [LEFT_W-1:0]   memory_left;
    } t_result;

    typedef struct packed {
        logic accept;
        logic adv;
    } t_ctl;

endpackage

`default_nettype wire

/* rtl/core/stt_if.sv */
// channel interfaces for items, results and the configuration write
`default_nettype none

interface stt_in_if import stt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [SIZE_W-1:0] seg_size;
    logic [ADDR_W-1:0] segment_number;
    logic [ADDR_W-1:0] seg_offset;
    modport source (output valid, func, seg_size, segment_number, seg_offset, input ready);
    modport sink   (input valid, func, seg_size, segment_number, seg_offset, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  segment_index;
    logic [ADDR_W-1:0] physical_address;
    logic [LEFT_W-1:0] memory_left;
    modport source (output valid, status, segment_index, physical_address, memory_left,
                    input ready);
    modport sink   (input valid, status, segment_index, physical_address, memory_left,
                    output ready);
endinterface

interface stt_cfg_if import stt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KIB_W-1:0] memory_kib;
    modport source (output valid, memory_kib, input ready);
    modport sink   (input valid, memory_kib, output ready);
endinterface

`default_nettype wire

/* rtl/core/stt_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/stt_exec.sv */
// table state, add and translate decisions, write-to-read bypass
`default_nettype none

module stt_exec import stt_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl                 i_ctl,
    input  wire t_item                i_item,
    input  wire logic [ENTRY_W-1:0]   i_rdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [KIB_W-1:0]     i_cfg_kib,
    output      logic                 o_we,
    output      logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] o_waddr,
    output      logic [ENTRY_W-1:0]   o_wdata,
    output      t_result              o_res
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = (IW > IDX_W) ? IW : IDX_W;

    logic [KIB_W-1:0]  r_kib;
    logic [CW-1:0]     r_count, n_count;
    logic [LEFT_W-1:0] r_next_free, n_next_free;
    logic              r_byp_valid;
    logic [IW-1:0]     r_byp_addr;
    t_entry            r_byp_entry;

    logic [KIB_W-1:0]  kib_sat;
    logic [LEFT_W-1:0] total;
    logic [LEFT_W-1:0] end_addr;
    logic              add_ok;
    t_entry            new_entry;
    t_entry            rd_entry;
    logic [PW-1:0]     idx_pad;
    logic [ADDR_W-1:0] phys_sum;

    assign kib_sat  = (r_kib > KIB_W'(KIB_MAX)) ? KIB_W'(KIB_MAX) : r_kib;
    assign total    = LEFT_W'(kib_sat) << KIB_SHIFT;
    assign end_addr = r_next_free + LEFT_W'(i_item.seg_size);

    assign new_entry.base = r_next_free[ADDR_W-1:0];
    assign new_entry.size = i_item.seg_size;

    assign rd_entry = (r_byp_valid && (i_item.segment_number[IW-1:0] == r_byp_addr))
                    ? r_byp_entry : t_entry'(i_rdata);

    assign idx_pad  = PW'(r_count[IW-1:0]);
    assign phys_sum = rd_entry.base + i_item.seg_offset;

    always_comb begin
        add_ok                 = 1'b0;
        o_res.status           = ST_OK;
        o_res.segment_index    = '0;
        o_res.physical_address = '0;
        unique case (i_item.func)
            FN_ADD: begin
                if (i_item.seg_size != '0) begin
                    priority if (r_count >= CW'(MAX_SEGMENTS)) begin
                        o_res.status = ST_FULL;
                    end else if (end_addr > total) begin
                        o_res.status = ST_NOMEM;
                    end else begin
                        add_ok              = 1'b1;
                        o_res.segment_index = idx_pad[IDX_W-1:0];
                    end
                end
            end
            FN_TRANSLATE: begin
                priority if (i_item.segment_number >= ADDR_W'(r_count)) begin
                    o_res.status = ST_SEGV;
                end else if (i_item.seg_offset >= rd_entry.size) begin
                    o_res.status = ST_SEGV;
                end else begin
                    o_res.physical_address = phys_sum;
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
        n_next_free       = add_ok ? end_addr : r_next_free;
        o_res.memory_left = (n_next_free >= total) ? '0 : (total - n_next_free);
    end

    assign n_count     = add_ok ? (r_count + CW'(1)) : r_count;

    assign o_we    = i_ctl.adv && add_ok;
    assign o_waddr = r_count[IW-1:0];
    assign o_wdata = ENTRY_W'(new_entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kib       <= KIB_RESET;
            r_count     <= '0;
            r_next_free <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kib <= i_cfg_kib;
            end
            if (i_ctl.adv) begin
                r_count     <= n_count;
                r_next_free <= n_next_free;
            end
            if (i_ctl.accept) begin
                r_byp_valid <= o_we;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_byp_addr  <= r_count[IW-1:0];
            r_byp_entry <= new_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/segment_table_translate.sv */
// top level of the segment table translator
// Segment table with base and bounds translation. One item is accepted per
// clock cycle while the output side does not stall; its result passes from the
// input register through the decision logic into the output register, which
// takes it when that register is empty or being read out. The
// descriptor table lives in a ram with a registered read port, read when the
// item is accepted; a segment added by the item just ahead is forwarded from a
// bypass register. The table has no clearing pass after reset: only entries
// below the current segment count are ever looked at.
`default_nettype none

module segment_table_translate import stt_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_in,
    stt_out_if.source  o_out,
    stt_cfg_if.sink    i_cfg
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    t_ctl                ctl;
    logic                accept;
    logic                adv;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_result             res;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign accept     = i_in.valid && i_in.ready;
    assign ctl.accept = accept;
    assign ctl.adv    = adv;

    assign i_cfg.ready = 1'b1;

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_in.segment_number[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    stt_exec #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_item    (r_in),
        .i_rdata   (ram_rdata),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_kib (i_cfg.memory_kib),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.func           <= t_func'(i_in.func);
            r_in.seg_size       <= i_in.seg_size;
            r_in.segment_number <= i_in.segment_number;
            r_in.seg_offset     <= i_in.seg_offset;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.segment_index    = r_out.segment_index;
    assign o_out.physical_address = r_out.physical_address;
    assign o_out.memory_left      = r_out.memory_left;

endmodule

`default_nettype wire

/* dv/segment_table_checker.sv */
// checker for the segment table translator: predicts each result and compares it
`timescale 1ns / 1ps

module segment_table_checker import stt_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stt_in_if         in_ch,
    stt_out_if        out_ch,
    stt_cfg_if        cfg_ch,
    output int        o_fail_count,
    output int        o_pending
);

    logic [ADDR_W-1:0] seg_base [MAX_SEGMENTS];
    logic [SIZE_W-1:0] seg_len  [MAX_SEGMENTS];
    int unsigned       seg_count;
    logic [LEFT_W-1:0] used_bytes;
    logic [KIB_W-1:0]  mem_kib;
    t_result           results_due [$];

    function automatic logic [LEFT_W-1:0] pool_bytes();
        logic [KIB_W-1:0] k;
        k = (mem_kib > KIB_W'(KIB_MAX)) ? KIB_W'(KIB_MAX) : mem_kib;
        return LEFT_W'(k) << KIB_SHIFT;
    endfunction

    function automatic t_result apply_item(t_item it);
        t_result         r;
        logic [LEFT_W:0] reach;
        r = '0;
        r.status = ST_OK;
        if (it.func == FN_ADD) begin
            if (it.seg_size != '0) begin
                reach = {1'b0, used_bytes} + (LEFT_W + 1)'(it.seg_size);
                if (seg_count >= MAX_SEGMENTS) begin
                    r.status = ST_FULL;
                end else if (reach > {1'b0, pool_bytes()}) begin
                    r.status = ST_NOMEM;
                end else begin
                    seg_base[seg_count] = used_bytes[ADDR_W-1:0];
                    seg_len[seg_count] = it.seg_size;
                    r.segment_index = IDX_W'(seg_count);
                    seg_count++;
                    used_bytes = reach[LEFT_W-1:0];
                end
            end
        end else if (it.segment_number >= seg_count) begin
            r.status = ST_SEGV;
        end else if (it.seg_offset >= seg_len[it.segment_number]) begin
            r.status = ST_SEGV;
        end else begin
            r.physical_address = seg_base[it.segment_number] + it.seg_offset;
        end
        r.memory_left = (used_bytes >= pool_bytes()) ? '0 : pool_bytes() - used_bytes;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            seg_count = 0;
            used_bytes = '0;
            mem_kib = KIB_RESET;
            results_due.delete();
            o_fail_count = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                mem_kib = cfg_ch.memory_kib;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected transaction, status %0d index %0d addr %0d left %0d",
                             $time, out_ch.status, out_ch.segment_index,
                             out_ch.physical_address, out_ch.memory_left);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("segment_index", want.segment_index, out_ch.segment_index);
                    check_field("physical_address", want.physical_address,
                                out_ch.physical_address);
                    check_field("memory_left", want.memory_left, out_ch.memory_left);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                it = '{func: t_func'(in_ch.func), seg_size: in_ch.seg_size,
                       segment_number: in_ch.segment_number, seg_offset: in_ch.seg_offset};
                results_due.push_back(apply_item(it));
            end
        end
        o_pending = results_due.size();
    end

endmodule

/* dv/tb_segment_table_translate.sv */
// testbench top for the segment table translator: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_segment_table_translate;
    import stt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 116;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm;
    int   stall_requests;
    logic [SIZE_W-1:0] size_pool [$];

    stt_in_if  in_ch ();
    stt_out_if out_ch ();
    stt_cfg_if cfg_ch ();

    segment_table_translate u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    segment_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 28);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(t_func f, logic [SIZE_W-1:0] size,
                             logic [ADDR_W-1:0] seg, logic [ADDR_W-1:0] off);
        while (idle_roll()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= f;
        in_ch.seg_size       <= size;
        in_ch.segment_number <= seg;
        in_ch.seg_offset     <= off;
        if (f == FN_ADD && size != '0) size_pool.push_back(size);
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_memory_kib(logic [KIB_W-1:0] kib);
        drain();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.memory_kib <= kib;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_item();
        int                r;
        int                c;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] seg;
        logic [ADDR_W-1:0] off;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, 99);
        size = $urandom_range(0, 65535);
        seg = $urandom_range(0, 65535);
        off = $urandom_range(0, 65535);
        if (r < 15) begin
            if (c < 8) size = '0;
            else if (c < 60) size = $urandom_range(1, 2047);
            else if (c < 80) size = $urandom_range(2048, 16383);
            else size = $urandom_range(1, 65535);
            send_item(FN_ADD, size, seg, off);
        end else if (r < 20) begin
            send_item(t_func'($urandom_range(0, 1)), size, seg, off);
        end else begin
            if ($urandom_range(0, 9) != 0) seg = $urandom_range(0, 8);
            if (c < 40 || size_pool.size() == 0) begin
                off = $urandom_range(0, 63);
            end else if (c < 75) begin
                off = size_pool[$urandom_range(0, size_pool.size() - 1)]
                      + ADDR_W'($urandom_range(0, 2)) - 1'b1;
            end
            send_item(FN_TRANSLATE, size, seg, off);
        end
    endtask

    initial begin : receiver
        int stalls_done;
        int hold;
        stalls_done = 0;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_requests != stalls_done) begin
                stalls_done = stall_requests;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("segment_table_translate regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [KIB_W-1:0] kib_menu [8];
        logic [KIB_W-1:0] kib;
        kib_menu = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd40, 7'd65, 7'd16, 7'd63};
        calm = 1'b0;
        stall_requests = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FN_ADD;
        in_ch.seg_size = '0;
        in_ch.segment_number = '0;
        in_ch.seg_offset = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.memory_kib = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, default memory
        send_item(FN_TRANSLATE, 16'h0000, 16'd0, 16'd0);
        send_item(FN_ADD, 16'd0, 16'hFFFF, 16'hFFFF);
        send_item(FN_ADD, 16'hFFFF, 16'd0, 16'd0);
        send_item(FN_ADD, 16'd16384, 16'd0, 16'd0);
        send_item(FN_ADD, 16'd1, 16'd0, 16'd0);
        send_item(FN_TRANSLATE, 16'd0, 16'd0, 16'd16383);
        send_item(FN_TRANSLATE, 16'd0, 16'd0, 16'd16384);
        send_item(FN_TRANSLATE, 16'd0, 16'd1, 16'd0);
        send_item(FN_TRANSLATE, 16'd0, 16'hFFFF, 16'd0);
        // memory shrunk below what is in use
        write_memory_kib(7'd0);
        send_item(FN_ADD, 16'd1, 16'd0, 16'd0);
        send_item(FN_TRANSLATE, 16'hFFFF, 16'd0, 16'd0);
        // above 64 KiB counts as 64 KiB
        write_memory_kib(7'd127);
        send_item(FN_ADD, 16'd100, 16'd0, 16'd0);
        send_item(FN_TRANSLATE, 16'd0, 16'd1, 16'd99);
        send_item(FN_TRANSLATE, 16'd0, 16'd1, 16'd100);
        send_item(FN_TRANSLATE, 16'd0, 16'd1, 16'hFFFF);
        send_item(FN_ADD, 16'd49053, 16'd0, 16'd0);
        write_memory_kib(7'd64);
        send_item(FN_TRANSLATE, 16'd0, 16'd0, 16'h8000);

        for (int phase = 0; phase < PHASES; phase++) begin
            kib = (phase < 8) ? kib_menu[phase] : KIB_W'($urandom_range(0, 127));
            write_memory_kib(kib);
            calm = (phase == 3);
            if (phase == 5) stall_requests++;
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("segment_table_translate regression: pass");
        end else begin
            $display("segment_table_translate regression: fail");
        end
        $finish;
    end

endmodule
